FILE: rtl/core/barometric_pressure_compensation_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the barometric pressure compensation core
// Implication checks, clocked and disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_CORE_MACROS_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BPC_ASSERT_IMP(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define BPC_ASSERT_NXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define BPC_ASSERT_IMP(label, clk, rstn, ante, cons)
`define BPC_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/core/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Constants, types and helpers shared by the compensation core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package bpc_pkg;

	localparam int DIV_W   = 32;
	localparam int DIV_LAT = DIV_W;

	localparam logic [1:0] CFG_COEF_A = 2'd0;
	localparam logic [1:0] CFG_COEF_B = 2'd1;
	localparam logic [1:0] CFG_COEF_C = 2'd2;
	localparam logic [1:0] CFG_OSS    = 2'd3;

	localparam logic [31:0] T_OFFSET  = 32'd4000;
	localparam logic [31:0] P_C1      = 32'd3038;
	localparam logic [31:0] P_C2      = 32'hFFFF_E343;
	localparam logic [31:0] P_C3      = 32'd3791;
	localparam logic [31:0] P_SCALE   = 32'd50000;
	localparam logic [31:0] B4_BIAS   = 32'd32768;

	typedef struct packed {
		logic [31:0] x1;
		logic [18:0] up;
		logic        neg;
		logic        fail;
	} tside_t;

	typedef struct packed {
		logic [27:0] temp;
		logic        fail;
		logic        shl;
	} pside_t;

	function automatic logic [31:0] sext16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/barometric_pressure_compensation_core.sv
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_core
// Fixed-point temperature and pressure compensation of a barometric sensor.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_*: one beat carries a raw temperature and raw pressure.
//   Master stream m_*: one beat carries the compensated temperature (0.1 C),
//   the pressure in pascal, and in tuser a status flag (1: zero divisor,
//   both results forced to zero).
//   Configuration channel cfg_*: always ready; index 0..3 selects the three
//   calibration words and the oversampling setting. Write only while idle.
// Pipeline: two 32-stage bit-per-stage dividers plus eight arithmetic stages
//   lie between an accepted input beat and its output beat.
// Throughput: one beat per cycle while the output is not stalled, set by the fully pipelined datapath.
// Reset: arst_n clears every valid bit and the configuration registers.
// Stall: when m_tready is low with a beat pending, the whole pipeline holds
//   and s_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "barometric_pressure_compensation_core_macros.svh"
module barometric_pressure_compensation_core import bpc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // raw_temperature[15:0], raw_pressure[34:16]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // temperature_tenths[27:0], pressure_pa[59:28]
	output logic [0:0]       m_tuser,   // status[0]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	// configuration registers
	logic [63:0] coef_a_q, coef_b_q;
	logic [31:0] coef_c_q;
	logic [1:0]  oss_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q <= '0;
			coef_b_q <= '0;
			coef_c_q <= '0;
			oss_q    <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_COEF_A: coef_a_q <= cfg_data;
				CFG_COEF_B: coef_b_q <= cfg_data;
				CFG_COEF_C: coef_c_q <= cfg_data[31:0];
				CFG_OSS:    oss_q    <= cfg_data[1:0];
				default:    coef_a_q <= coef_a_q;
			endcase
		end
	end

	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	assign ac1 = sext16(coef_a_q[15:0]);
	assign ac2 = sext16(coef_a_q[31:16]);
	assign ac3 = sext16(coef_a_q[47:32]);
	assign ac4 = {16'd0, coef_a_q[63:48]};
	assign ac5 = {16'd0, coef_b_q[15:0]};
	assign ac6 = {16'd0, coef_b_q[31:16]};
	assign b1  = sext16(coef_b_q[47:32]);
	assign b2  = sext16(coef_b_q[63:48]);
	assign mc  = sext16(coef_c_q[15:0]);
	assign md  = sext16(coef_c_q[31:16]);

	// advance the whole pipeline unless the output beat is stuck
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// stage 1: (ut - ac6) * ac5
	logic        v_s1;
	logic [31:0] prod_t_s1;
	logic [18:0] up_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_t_s1 <= ({16'd0, s_tdata[15:0]} - ac6) * ac5;
			up_s1     <= s_tdata[34:16];
		end
	end

	// temperature divisor set-up, signs split off for an unsigned divide
	logic [31:0] x1_t, den_t, num_t, mag_n, mag_d;
	tside_t      tside_in;
	assign x1_t  = $signed(prod_t_s1) >>> 15;
	assign den_t = x1_t + md;
	assign num_t = mc << 11;
	assign mag_n = num_t[31] ? (32'd0 - num_t) : num_t;
	assign mag_d = den_t[31] ? (32'd0 - den_t) : den_t;
	assign tside_in = '{x1: x1_t, up: up_s1, neg: num_t[31] ^ den_t[31],
		fail: (den_t == 32'd0)};

	logic        tdiv_v;
	logic [31:0] tdiv_q;

	bpc_udiv u_tdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.num       (mag_n),
		.den       (mag_d),
		.out_valid (tdiv_v),
		.quo       (tdiv_q)
	);

	// side data travels alongside the divider stages
	tside_t tdly_q [0:DIV_LAT-1];
	always_ff @(posedge clk) begin
		if (en) begin
			tdly_q[0] <= tside_in;
			for (int k = 1; k < DIV_LAT; k++) tdly_q[k] <= tdly_q[k-1];
		end
	end

	// stage 3: b5, temperature, products of b6
	tside_t      ts;
	logic [31:0] b5, b6, t_full;
	assign ts     = tdly_q[DIV_LAT-1];
	assign b5     = ts.x1 + (ts.neg ? (32'd0 - tdiv_q) : tdiv_q);
	assign b6     = b5 - T_OFFSET;
	assign t_full = $signed(b5 + 32'd8) >>> 4;

	logic        v_s3, fail_s3;
	logic [27:0] temp_s3;
	logic [18:0] up_s3;
	logic [31:0] b6b6_s3, ac2b6_s3, ac3b6_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= tdiv_v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fail_s3  <= ts.fail;
			temp_s3  <= t_full[27:0];
			up_s3    <= ts.up;
			b6b6_s3  <= b6 * b6;
			ac2b6_s3 <= ac2 * b6;
			ac3b6_s3 <= ac3 * b6;
		end
	end

	// stage 4: sq and its products
	logic [31:0] sq;
	assign sq = $signed(b6b6_s3) >>> 12;

	logic        v_s4, fail_s4;
	logic [27:0] temp_s4;
	logic [18:0] up_s4;
	logic [31:0] x2a_s4, x1c_s4, b2sq_s4, b1sq_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fail_s4 <= fail_s3;
			temp_s4 <= temp_s3;
			up_s4   <= up_s3;
			x2a_s4  <= $signed(ac2b6_s3) >>> 11;
			x1c_s4  <= $signed(ac3b6_s3) >>> 13;
			b2sq_s4 <= b2 * sq;
			b1sq_s4 <= b1 * sq;
		end
	end

	// stage 5: b3 and the b4 operand
	logic [31:0] x1b, x3b, b3_pre, b3, x2c, x3c_sum, x3c;
	assign x1b     = $signed(b2sq_s4) >>> 11;
	assign x3b     = x1b + x2a_s4;
	assign b3_pre  = ((ac1 << 2) + x3b) << oss_q;
	assign b3      = $signed(b3_pre + 32'd2) >>> 2;
	assign x2c     = $signed(b1sq_s4) >>> 16;
	assign x3c_sum = x1c_s4 + x2c + 32'd2;
	assign x3c     = $signed(x3c_sum) >>> 2;

	logic        v_s5, fail_s5;
	logic [27:0] temp_s5;
	logic [31:0] upb3_s5, b4op_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fail_s5 <= fail_s4;
			temp_s5 <= temp_s4;
			upb3_s5 <= {13'd0, up_s4} - b3;
			b4op_s5 <= x3c + B4_BIAS;
		end
	end

	// stage 6: b4 and b7 products
	logic        v_s6, fail_s6;
	logic [27:0] temp_s6;
	logic [31:0] b4p_s6, b7_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fail_s6 <= fail_s5;
			temp_s6 <= temp_s5;
			b4p_s6  <= ac4 * b4op_s5;
			b7_s6   <= upb3_s5 * (P_SCALE >> oss_q);
		end
	end

	// pressure division: double before dividing unless b7 has its top bit set
	logic [31:0] b4, num_p;
	pside_t      pside_in;
	assign b4    = b4p_s6 >> 15;
	assign num_p = b7_s6[31] ? b7_s6 : (b7_s6 << 1);
	assign pside_in = '{temp: temp_s6, fail: fail_s6 || (b4 == 32'd0),
		shl: b7_s6[31]};

	logic        pdiv_v;
	logic [31:0] pdiv_q;

	bpc_udiv u_pdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s6),
		.num       (num_p),
		.den       (b4),
		.out_valid (pdiv_v),
		.quo       (pdiv_q)
	);

	pside_t pdly_q [0:DIV_LAT-1];
	always_ff @(posedge clk) begin
		if (en) begin
			pdly_q[0] <= pside_in;
			for (int k = 1; k < DIV_LAT; k++) pdly_q[k] <= pdly_q[k-1];
		end
	end

	// stage 8: p and its first products
	pside_t      ps;
	logic [31:0] p, p8;
	assign ps = pdly_q[DIV_LAT-1];
	assign p  = ps.shl ? (pdiv_q << 1) : pdiv_q;
	assign p8 = $signed(p) >>> 8;

	logic        v_s8, fail_s8;
	logic [27:0] temp_s8;
	logic [31:0] p_s8, pp_s8, m2_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else if (en) v_s8 <= pdiv_v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fail_s8 <= ps.fail;
			temp_s8 <= ps.temp;
			p_s8    <= p;
			pp_s8   <= p8 * p8;
			m2_s8   <= P_C2 * p;
		end
	end

	// stage 9: scale the square term
	logic        v_s9, fail_s9;
	logic [27:0] temp_s9;
	logic [31:0] p_s9, x1p_s9, x2p_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s9 <= 1'b0;
		else if (en) v_s9 <= v_s8;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fail_s9 <= fail_s8;
			temp_s9 <= temp_s8;
			p_s9    <= p_s8;
			x1p_s9  <= pp_s8 * P_C1;
			x2p_s9  <= $signed(m2_s8) >>> 16;
		end
	end

	// stage 10: final pressure, output register
	logic [31:0] x1p, corr, pres;
	assign x1p  = $signed(x1p_s9) >>> 16;
	assign corr = x1p + x2p_s9 + P_C3;
	assign pres = p_s9 + 32'($signed(corr) >>> 4);

	logic        v_s10, fail_s10;
	logic [27:0] temp_s10;
	logic [31:0] pres_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s10 <= 1'b0;
		else if (en) v_s10 <= v_s9;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fail_s10 <= fail_s9;
			temp_s10 <= fail_s9 ? 28'd0 : temp_s9;
			pres_s10 <= fail_s9 ? 32'd0 : pres;
		end
	end

	assign m_tvalid = v_s10;
	assign m_tdata  = {4'd0, pres_s10, temp_s10};
	assign m_tuser  = fail_s10;

	`BPC_ASSERT_IMP(a_fail_zero, clk, arst_n, m_tvalid && m_tuser[0], m_tdata == 64'd0)
	`BPC_ASSERT_NXT(a_hold_s1, clk, arst_n, v_s1 && !en, v_s1)
	`BPC_ASSERT_NXT(a_hold_s3, clk, arst_n, v_s3 && !en, v_s3 && $stable(fail_s3))

endmodule
`default_nettype wire

FILE: rtl/core/bpc_udiv.sv
// ----------------------------------------------------------------------------
// bpc_udiv
// Unsigned 32/32 restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bpc_udiv import bpc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [DIV_W-1:0]  num,
	input  wire logic [DIV_W-1:0]  den,
	output logic                   out_valid,
	output logic [DIV_W-1:0]       quo
);

	logic             vld_s [1:DIV_LAT];
	logic [DIV_W-1:0] num_s [1:DIV_LAT];
	logic [DIV_W-1:0] den_s [1:DIV_LAT];
	logic [DIV_W-1:0] rem_s [1:DIV_LAT];
	logic [DIV_W-1:0] quo_s [1:DIV_LAT];

	for (genvar k = 1; k <= DIV_LAT; k++) begin : g_stage
		logic             pv;
		logic [DIV_W-1:0] pn, pd, pr, pq;
		logic [DIV_W:0]   trial, diff;
		logic             ge;

		if (k == 1) begin : g_first
			assign pv = in_valid;
			assign pn = num;
			assign pd = den;
			assign pr = '0;
			assign pq = '0;
		end else begin : g_next
			assign pv = vld_s[k-1];
			assign pn = num_s[k-1];
			assign pd = den_s[k-1];
			assign pr = rem_s[k-1];
			assign pq = quo_s[k-1];
		end

		// shift in the next numerator bit, subtract where it fits
		assign trial = {pr, pn[DIV_W-k]};
		assign diff  = trial - {1'b0, pd};
		assign ge    = (trial >= {1'b0, pd});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[k] <= pn;
				den_s[k] <= pd;
				rem_s[k] <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
				quo_s[k] <= {pq[DIV_W-2:0], ge};
			end
		end
	end

	assign out_valid = vld_s[DIV_LAT];
	assign quo       = quo_s[DIV_LAT];

endmodule
`default_nettype wire
